FILE: design/ltp_pkg.sv
// ----------------------------------------------------------------------------
// Loop termination predictor package
// Shared constants, field widths and the control state type.
// ----------------------------------------------------------------------------
package ltp_pkg;

  localparam int unsigned SETS_DEF         = 256;
  localparam int unsigned WAYS_DEF         = 4;
  localparam int unsigned TAG_W_DEF        = 14;
  localparam int unsigned COUNT_BITS_DEF   = 14;
  localparam int unsigned USE_CTR_BITS_DEF = 7;

  localparam int unsigned AGE_BITS  = 8;
  localparam int unsigned CONF_BITS = 2;

  localparam logic [AGE_BITS-1:0]  AGE_MAX  = 8'd255;
  localparam logic [CONF_BITS-1:0] CONF_MAX = 2'd3;
  localparam int unsigned          MIN_TRIP = 3;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

endpackage

FILE: design/ltp_table.sv
// ----------------------------------------------------------------------------
// Loop table memory
// One row per set holding all ways; one write port and one registered read port.
// ----------------------------------------------------------------------------
module ltp_table #(
  parameter int unsigned SETS = 256,
  parameter int unsigned RW   = 212,
  parameter int unsigned AW   = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [RW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [RW-1:0] rdata_o
);

  logic [RW-1:0] mem_q [SETS];
  logic [RW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ltp_update.sv
// ----------------------------------------------------------------------------
// Loop table row update
// Tag search, prediction, entry update, allocation and usefulness counter step.
// ----------------------------------------------------------------------------
module ltp_update #(
  parameter int unsigned WAYS         = 4,
  parameter int unsigned TAG_W        = 14,
  parameter int unsigned COUNT_BITS   = 14,
  parameter int unsigned USE_CTR_BITS = 7,
  parameter int unsigned EW = TAG_W + 2 * COUNT_BITS + ltp_pkg::CONF_BITS + ltp_pkg::AGE_BITS,
  parameter int unsigned RW = WAYS * EW
) (
  input  logic [RW-1:0]                  row_i,
  input  logic [TAG_W-1:0]               tag_i,
  input  logic                           taken_i,
  input  logic                           guess_i,
  input  logic signed [USE_CTR_BITS-1:0] ctr_i,
  output logic [RW-1:0]                  row_o,
  output logic                           offer_o,
  output logic                           dir_o,
  output logic signed [USE_CTR_BITS-1:0] ctr_o
);

  import ltp_pkg::*;

  localparam int unsigned AGE_LO  = 0;
  localparam int unsigned CONF_LO = AGE_BITS;
  localparam int unsigned ITER_LO = CONF_LO + CONF_BITS;
  localparam int unsigned TRIP_LO = ITER_LO + COUNT_BITS;
  localparam int unsigned TAG_LO  = TRIP_LO + COUNT_BITS;

  localparam logic [USE_CTR_BITS-1:0] CTR_MAX = {1'b0, {(USE_CTR_BITS-1){1'b1}}};
  localparam logic [USE_CTR_BITS-1:0] CTR_MIN = {1'b1, {(USE_CTR_BITS-1){1'b0}}};

  logic [TAG_W-1:0]      tg   [WAYS];
  logic [COUNT_BITS-1:0] trip [WAYS];
  logic [COUNT_BITS-1:0] iter [WAYS];
  logic [CONF_BITS-1:0]  conf [WAYS];
  logic [AGE_BITS-1:0]   age  [WAYS];
  logic [WAYS-1:0]       hit_sel;
  logic                  hit;

  logic [COUNT_BITS-1:0] s_trip;
  logic [COUNT_BITS:0]   s_iter;
  logic [CONF_BITS-1:0]  s_conf;
  logic [AGE_BITS-1:0]   s_age;
  logic                  pred;
  logic                  conf_hit;

  always_comb begin
    hit     = 1'b0;
    hit_sel = '0;
    for (int w = 0; w < WAYS; w++) begin
      tg[w]   = row_i[w*EW+TAG_LO  +: TAG_W];
      trip[w] = row_i[w*EW+TRIP_LO +: COUNT_BITS];
      iter[w] = row_i[w*EW+ITER_LO +: COUNT_BITS];
      conf[w] = row_i[w*EW+CONF_LO +: CONF_BITS];
      age[w]  = row_i[w*EW+AGE_LO  +: AGE_BITS];
      if (!hit && tg[w] == tag_i) begin
        hit_sel[w] = 1'b1;
        hit        = 1'b1;
      end
    end
  end

  always_comb begin
    s_trip = '0;
    s_iter = '0;
    s_conf = '0;
    s_age  = '0;
    for (int w = 0; w < WAYS; w++) begin
      s_trip = s_trip | (trip[w] & {COUNT_BITS{hit_sel[w]}});
      s_iter = s_iter | {1'b0, iter[w] & {COUNT_BITS{hit_sel[w]}}};
      s_conf = s_conf | (conf[w] & {CONF_BITS{hit_sel[w]}});
      s_age  = s_age  | (age[w]  & {AGE_BITS{hit_sel[w]}});
    end

    conf_hit = hit && (s_conf == CONF_MAX);
    pred     = ((s_iter + 1'b1) == {1'b0, s_trip}) ? 1'b0 : 1'b1;
    offer_o  = conf_hit && !ctr_i[USE_CTR_BITS-1];
    dir_o    = offer_o && pred;

    ctr_o = ctr_i;
    if (conf_hit && (pred != guess_i)) begin
      if (pred == taken_i) begin
        if (ctr_i != CTR_MAX) begin
          ctr_o = ctr_i + 1'b1;
        end
      end else begin
        if (ctr_i != CTR_MIN) begin
          ctr_o = ctr_i - 1'b1;
        end
      end
    end

    if (conf_hit) begin
      if (pred != taken_i) begin
        s_trip = '0;
        s_iter = '0;
        s_conf = '0;
        s_age  = '0;
      end else if (pred != guess_i && s_age != AGE_MAX) begin
        s_age = s_age + 1'b1;
      end
    end

    s_iter = s_iter + 1'b1;
    if (s_iter > {1'b0, s_trip}) begin
      if (s_trip != '0 || s_iter[COUNT_BITS]) begin
        s_trip = '0;
        s_iter = '0;
        s_conf = '0;
        s_age  = '0;
      end else begin
        s_conf = '0;
      end
    end

    if (!taken_i) begin
      if (s_iter == {1'b0, s_trip}) begin
        if (s_conf != CONF_MAX) begin
          s_conf = s_conf + 1'b1;
        end
        if (s_trip < COUNT_BITS'(MIN_TRIP)) begin
          s_trip = '0;
          s_iter = '0;
          s_conf = '0;
          s_age  = '0;
        end
      end else if (s_trip == '0) begin
        s_conf = '0;
        s_trip = s_iter[COUNT_BITS-1:0];
      end else begin
        s_trip = '0;
        s_iter = '0;
        s_conf = '0;
        s_age  = '0;
      end
      s_iter = '0;
    end
  end

  always_comb begin
    logic alloc_done;
    alloc_done = 1'b0;
    row_o      = row_i;
    for (int w = 0; w < WAYS; w++) begin
      if (hit) begin
        if (hit_sel[w]) begin
          row_o[w*EW+TRIP_LO +: COUNT_BITS] = s_trip;
          row_o[w*EW+ITER_LO +: COUNT_BITS] = s_iter[COUNT_BITS-1:0];
          row_o[w*EW+CONF_LO +: CONF_BITS]  = s_conf;
          row_o[w*EW+AGE_LO  +: AGE_BITS]   = s_age;
        end
      end else if (taken_i && !alloc_done) begin
        if (age[w] == '0) begin
          row_o[w*EW+TAG_LO  +: TAG_W]      = tag_i;
          row_o[w*EW+TRIP_LO +: COUNT_BITS] = '0;
          row_o[w*EW+ITER_LO +: COUNT_BITS] = '0;
          row_o[w*EW+CONF_LO +: CONF_BITS]  = '0;
          row_o[w*EW+AGE_LO  +: AGE_BITS]   = AGE_MAX;
          alloc_done = 1'b1;
        end else begin
          row_o[w*EW+AGE_LO +: AGE_BITS] = age[w] - 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/loop_termination_predictor_unit.sv
// ----------------------------------------------------------------------------
// Loop termination predictor unit
// Set-associative loop table that predicts loop exits for resolved branches.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+---------------------------------------------
//  branch   | start_i / busy_o   | branch_address_i, actual_taken_i, main_guess_i
//  result   | done_o (one cycle) | prediction_valid_o, predicted_taken_o
//
//  The set row is read from the table memory at the edge of the transfer and
//  written back at the next edge, when the result is registered and done_o
//  rises. This read-modify-write of one row sets the rate; a new branch may be
//  accepted at the edge where the result transfer completes.
//  After reset all SETS rows are cleared, one row a cycle, with busy_o high.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module loop_termination_predictor_unit #(
  parameter int unsigned SETS         = ltp_pkg::SETS_DEF,
  parameter int unsigned WAYS         = ltp_pkg::WAYS_DEF,
  parameter int unsigned TAG_W        = ltp_pkg::TAG_W_DEF,
  parameter int unsigned COUNT_BITS   = ltp_pkg::COUNT_BITS_DEF,
  parameter int unsigned USE_CTR_BITS = ltp_pkg::USE_CTR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] branch_address_i,
  input  logic        actual_taken_i,
  input  logic        main_guess_i,
  output logic        done_o,
  output logic        prediction_valid_o,
  output logic        predicted_taken_o
);

  import ltp_pkg::*;

  localparam int unsigned EW       = TAG_W + 2 * COUNT_BITS + CONF_BITS + AGE_BITS;
  localparam int unsigned RW       = WAYS * EW;
  localparam int unsigned AW       = $clog2(SETS);
  localparam int unsigned IDX_BITS = $clog2(SETS + 1) - 1;
  localparam logic [AW-1:0] SET_MASK = AW'(SETS - 1);

  state_e state_q, state_d;
  logic [AW-1:0]                  clr_q;
  logic signed [USE_CTR_BITS-1:0] ctr_q;
  logic signed [USE_CTR_BITS-1:0] ctr_d;
  logic [AW-1:0]                  set_q;
  logic [TAG_W-1:0]               tag_q;
  logic                           taken_q;
  logic                           guess_q;
  logic                           done_q;
  logic                           pvalid_q;
  logic                           ptaken_q;

  logic                accept;
  logic [AW-1:0]       set_d;
  logic [31:0]         addr_shift;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [RW-1:0]       wdata;
  logic [RW-1:0]       rdata;
  logic [RW-1:0]       new_row;
  logic                offer;
  logic                dir;

  assign busy_o     = (state_q != ST_IDLE);
  assign accept     = start_i && (state_q == ST_IDLE);
  assign set_d      = branch_address_i[AW-1:0] & SET_MASK;
  assign addr_shift = branch_address_i >> IDX_BITS;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = set_q;
    wdata = new_row;
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (state_q == ST_UPDATE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ctr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_UPDATE);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_UPDATE) begin
        ctr_q <= ctr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q   <= set_d;
      tag_q   <= addr_shift[TAG_W-1:0];
      taken_q <= actual_taken_i;
      guess_q <= main_guess_i;
    end
    if (state_q == ST_UPDATE) begin
      pvalid_q <= offer;
      ptaken_q <= dir;
    end
  end

  ltp_table #(
    .SETS (SETS),
    .RW   (RW),
    .AW   (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (set_d),
    .rdata_o (rdata)
  );

  ltp_update #(
    .WAYS         (WAYS),
    .TAG_W        (TAG_W),
    .COUNT_BITS   (COUNT_BITS),
    .USE_CTR_BITS (USE_CTR_BITS),
    .EW           (EW),
    .RW           (RW)
  ) u_update (
    .row_i   (rdata),
    .tag_i   (tag_q),
    .taken_i (taken_q),
    .guess_i (guess_q),
    .ctr_i   (ctr_q),
    .row_o   (new_row),
    .offer_o (offer),
    .dir_o   (dir),
    .ctr_o   (ctr_d)
  );

  assign done_o             = done_q;
  assign prediction_valid_o = pvalid_q;
  assign predicted_taken_o  = ptaken_q;

endmodule

FILE: design/ltp_checker.sv
// ----------------------------------------------------------------------------
// Loop termination predictor port checker
// Timing relations between transfers and results, bound to the top level.
// ----------------------------------------------------------------------------
module ltp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic prediction_valid_o,
  input logic predicted_taken_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("Unit not busy after a branch transfer.");

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("Result not delivered two cycles after a branch transfer.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Results delivered in consecutive cycles.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("Unit busy while a result is shown.");

  a_no_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !prediction_valid_o |-> !predicted_taken_o)
    else $error("Direction set without a prediction.");

endmodule

bind loop_termination_predictor_unit ltp_checker u_ltp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start_i),
  .busy_o             (busy_o),
  .done_o             (done_o),
  .prediction_valid_o (prediction_valid_o),
  .predicted_taken_o  (predicted_taken_o)
);

FILE: tb/tb_loop_termination_predictor_unit.sv
// ----------------------------------------------------------------------------
// Loop termination predictor unit testbench
// Resolved branches are driven in random bursts through the start/busy
// handshake. A scoreboard keeps its own copy of the loop table and the
// usefulness counter, works out the prediction for each accepted branch and
// checks every result transfer in order. The stimulus covers the extremes of
// the address, trained loops with random guesses, broken loops and saturation
// of the usefulness counter at both limits.
// ----------------------------------------------------------------------------
module tb_loop_termination_predictor_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETS         = ltp_pkg::SETS_DEF;
  localparam int unsigned WAYS         = ltp_pkg::WAYS_DEF;
  localparam int unsigned TAG_W        = ltp_pkg::TAG_W_DEF;
  localparam int unsigned COUNT_BITS   = ltp_pkg::COUNT_BITS_DEF;
  localparam int unsigned USE_CTR_BITS = ltp_pkg::USE_CTR_BITS_DEF;
  localparam int unsigned IDX_BITS     = $clog2(SETS);
  localparam int          CTR_MAX      = (1 << (USE_CTR_BITS - 1)) - 1;
  localparam int          CTR_MIN      = -(1 << (USE_CTR_BITS - 1));
  localparam int          POOL_SIZE    = 32;

  typedef struct packed {
    logic valid;
    logic dir;
  } prediction_t;

  typedef enum int {
    GUESS_RANDOM,
    GUESS_AGREE,
    GUESS_OPPOSE
  } guess_mode_e;

  class ltp_scoreboard;
    bit [TAG_W-1:0]              tags  [SETS][WAYS];
    bit [COUNT_BITS-1:0]         trips [SETS][WAYS];
    bit [COUNT_BITS-1:0]         iters [SETS][WAYS];
    bit [ltp_pkg::CONF_BITS-1:0] confs [SETS][WAYS];
    bit [ltp_pkg::AGE_BITS-1:0]  ages  [SETS][WAYS];
    int                          use_ctr;
    prediction_t                 expected_predictions[$];
    int                          mismatches;

    function int way_of(logic [31:0] addr);
      int s;
      s = int'(addr[IDX_BITS-1:0]);
      for (int w = 0; w < WAYS; w++) begin
        if (tags[s][w] == addr[IDX_BITS +: TAG_W]) return w;
      end
      return -1;
    endfunction

    function int conf_of(logic [31:0] addr);
      int w;
      w = way_of(addr);
      return (w < 0) ? -1 : int'(confs[addr[IDX_BITS-1:0]][w]);
    endfunction

    function int iter_of(logic [31:0] addr);
      int w;
      w = way_of(addr);
      return (w < 0) ? 0 : int'(iters[addr[IDX_BITS-1:0]][w]);
    endfunction

    function int pending();
      return expected_predictions.size();
    endfunction

    function void free_entry(int s, int w);
      trips[s][w] = '0;
      iters[s][w] = '0;
      confs[s][w] = '0;
      ages[s][w]  = '0;
    endfunction

    function void note_branch(logic [31:0] addr, logic taken, logic guess);
      int               s;
      int               w;
      bit               pred;
      bit               placed;
      bit [COUNT_BITS:0] nxt;
      prediction_t      res;
      s   = int'(addr[IDX_BITS-1:0]);
      w   = way_of(addr);
      res = '0;
      if (w >= 0) begin
        if (confs[s][w] == ltp_pkg::CONF_MAX) begin
          nxt  = {1'b0, iters[s][w]} + 1'b1;
          pred = (nxt != {1'b0, trips[s][w]});
          if (use_ctr >= 0) begin
            res.valid = 1'b1;
            res.dir   = pred;
          end
          if (pred != taken) begin
            free_entry(s, w);
          end else if (pred != guess && ages[s][w] != ltp_pkg::AGE_MAX) begin
            ages[s][w]++;
          end
          if (pred != guess) begin
            if (pred == taken) begin
              if (use_ctr < CTR_MAX) use_ctr++;
            end else begin
              if (use_ctr > CTR_MIN) use_ctr--;
            end
          end
        end
        nxt         = {1'b0, iters[s][w]} + 1'b1;
        iters[s][w] = nxt[COUNT_BITS-1:0];
        if (nxt > {1'b0, trips[s][w]}) begin
          if (trips[s][w] != 0 || nxt[COUNT_BITS]) begin
            free_entry(s, w);
          end else begin
            confs[s][w] = '0;
          end
        end
        if (!taken) begin
          if (iters[s][w] == trips[s][w]) begin
            if (confs[s][w] != ltp_pkg::CONF_MAX) confs[s][w]++;
            if (trips[s][w] < ltp_pkg::MIN_TRIP) free_entry(s, w);
          end else if (trips[s][w] == 0) begin
            confs[s][w] = '0;
            trips[s][w] = iters[s][w];
          end else begin
            free_entry(s, w);
          end
          iters[s][w] = '0;
        end
      end else if (taken) begin
        placed = 1'b0;
        for (int v = 0; v < WAYS; v++) begin
          if (!placed) begin
            if (ages[s][v] == 0) begin
              tags[s][v]  = addr[IDX_BITS +: TAG_W];
              trips[s][v] = '0;
              iters[s][v] = '0;
              confs[s][v] = '0;
              ages[s][v]  = ltp_pkg::AGE_MAX;
              placed      = 1'b1;
            end else begin
              ages[s][v]--;
            end
          end
        end
      end
      expected_predictions.push_back(res);
    endfunction

    function void check_prediction(logic valid, logic dir);
      prediction_t exp_res;
      if (expected_predictions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transfer: valid=%b taken=%b", valid, dir);
      end else begin
        exp_res = expected_predictions.pop_front();
        if (valid !== exp_res.valid || dir !== exp_res.dir) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected valid=%b taken=%b, got valid=%b taken=%b",
                     exp_res.valid, exp_res.dir, valid, dir);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] branch_address_i;
  logic        actual_taken_i;
  logic        main_guess_i;
  logic        done_o;
  logic        prediction_valid_o;
  logic        predicted_taken_o;

  ltp_scoreboard sb = new();
  logic [31:0]   addr_pool [POOL_SIZE];
  int            burst_left;
  int            n_sent;

  loop_termination_predictor_unit #(
    .SETS         (SETS),
    .WAYS         (WAYS),
    .TAG_W        (TAG_W),
    .COUNT_BITS   (COUNT_BITS),
    .USE_CTR_BITS (USE_CTR_BITS)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .branch_address_i   (branch_address_i),
    .actual_taken_i     (actual_taken_i),
    .main_guess_i       (main_guess_i),
    .done_o             (done_o),
    .prediction_valid_o (prediction_valid_o),
    .predicted_taken_o  (predicted_taken_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_prediction(prediction_valid_o, predicted_taken_o);
  end

  function automatic logic [31:0] fresh_address();
    logic [31:0] a;
    a = $urandom;
    case ($urandom_range(0, 5))
      0: a[IDX_BITS +: TAG_W] = '0;
      1: a[IDX_BITS +: TAG_W] = '1;
      default: ;
    endcase
    if ($urandom_range(0, 9) < 7) a[IDX_BITS-1:0] = IDX_BITS'($urandom_range(0, 7));
    return a;
  endfunction

  function automatic logic pick_guess(guess_mode_e mode, logic taken);
    case (mode)
      GUESS_AGREE:  return taken;
      GUESS_OPPOSE: return !taken;
      default:      return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_branch(input logic [31:0] addr, input logic taken, input logic guess);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                               : $urandom_range(40, 200);
    end
    start_i          <= 1'b1;
    branch_address_i <= addr;
    actual_taken_i   <= taken;
    main_guess_i     <= guess;
    do @(posedge clk_i); while (busy_o);
    sb.note_branch(addr, taken, guess);
    burst_left--;
    n_sent++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_loop(input logic [31:0] addr, input int trip, input int reps,
                          input guess_mode_e mode, input bit cut);
    int len;
    logic taken;
    for (int r = 0; r < reps; r++) begin
      len = (cut && r == reps - 1) ? $urandom_range(1, trip + 2) : trip;
      for (int i = 0; i < len; i++) begin
        taken = (i != len - 1);
        send_branch(addr, taken, pick_guess(mode, taken));
      end
    end
  endtask

  task automatic random_phase(input int count);
    int stop;
    stop = n_sent + count;
    while (n_sent < stop) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) == 0)
          addr_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_address();
        run_loop(addr_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom_range(1, 10),
                 $urandom_range(1, 8), guess_mode_e'($urandom_range(0, 2)),
                 $urandom_range(0, 2) == 0);
      end else begin
        send_branch($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Trains one loop and breaks it at each confident first iteration while the
  // main guess agrees with the outcome, so every break lowers the counter until it reaches its minimum.
  task automatic drive_counter_down();
    logic [31:0] a;
    int          trip;
    int          floor_hits;
    int          guard;
    a          = fresh_address();
    trip       = $urandom_range(3, 4);
    floor_hits = 0;
    guard      = 0;
    while (floor_hits < 3 && guard < 10000) begin
      if (sb.conf_of(a) == int'(ltp_pkg::CONF_MAX) && sb.iter_of(a) == 0) begin
        if (sb.use_ctr == CTR_MIN) floor_hits++;
        send_branch(a, 1'b0, 1'b0);
      end else begin
        run_loop(a, trip, 1, GUESS_AGREE, 1'b0);
      end
      guard++;
    end
  endtask

  task automatic drive_counter_up();
    logic [31:0] a;
    int          trip;
    int          ceil_reps;
    int          guard;
    a         = fresh_address();
    trip      = $urandom_range(3, 6);
    ceil_reps = 0;
    guard     = 0;
    while (ceil_reps < 10 && guard < 5000) begin
      run_loop(a, trip, 1, GUESS_OPPOSE, 1'b0);
      if (sb.use_ctr == CTR_MAX) ceil_reps++;
      guard++;
    end
  endtask

  task automatic run_directed();
    send_branch(32'h0000_0000, 1'b0, 1'b0);
    send_branch(32'h0000_0000, 1'b1, 1'b1);
    send_branch(32'hFFC0_0000, 1'b0, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_branch(32'h003F_FF00, 1'b1, 1'b0);
    send_branch(32'h003F_FF00, 1'b0, 1'b0);
    for (int i = 1; i <= 6; i++) send_branch({18'h0, 6'(i), 8'h05}, 1'b1, 1'b0);
    send_branch(32'h0000_0105, 1'b0, 1'b1);
    send_branch(32'h0000_0605, 1'b0, 1'b0);
    send_branch(32'hAAAA_AAAA, 1'b1, 1'b0);
    send_branch(32'h5555_5555, 1'b1, 1'b1);
    send_branch(32'h8000_0080, 1'b0, 1'b1);
  endtask

  initial begin
    rst_ni           <= 1'b0;
    start_i          <= 1'b0;
    branch_address_i <= '0;
    actual_taken_i   <= 1'b0;
    main_guess_i     <= 1'b0;
    burst_left = 0;
    n_sent     = 0;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = fresh_address();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    wait_drained();
    random_phase(600);
    wait_drained();
    drive_counter_down();
    random_phase(150);
    drive_counter_up();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
